@@ rtl/mmb_pkg.sv @@
`default_nettype none

package mmb_pkg;

   // playback phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_LIT   = 5'b00010,
      PH_EGAP  = 5'b00100,
      PH_LGAP  = 5'b01000,
      PH_SPACE = 5'b10000
   } phase_type;

   // command codes on the func field
   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_APPEND = 3'd1;
   localparam logic [2:0] FUNC_DELETE = 3'd2;
   localparam logic [2:0] FUNC_CLEAR  = 3'd3;
   localparam logic [2:0] FUNC_START  = 3'd4;

   localparam logic [7:0] PRESS_LAST_LETTER = 8'd26;
   localparam logic [7:0] PRESS_SPACE       = 8'd30;
   localparam logic [4:0] SPACE_CODE        = 5'd26;
   localparam int         LETTER_COUNT      = 26;

   localparam logic [2:0] UNITS_DOT   = 3'd1;
   localparam logic [2:0] UNITS_EGAP  = 3'd2;
   localparam logic [2:0] UNITS_DASH  = 3'd3;
   localparam logic [2:0] UNITS_LGAP  = 3'd3;
   localparam logic [2:0] UNITS_SPACE = 3'd7;
   localparam logic [2:0] MAX_ELEMENTS = 3'd4;

   localparam logic [7:0] UNIT_MS_RESET = 8'd100;

   // dash[i] set when element i is a dash, len = number of elements
   typedef struct packed {
      logic [3:0] dash;
      logic [2:0] len;
   } shape_type;

   localparam shape_type SHAPES [LETTER_COUNT] = '{
      '{4'b0010, 3'd2}, '{4'b0001, 3'd4}, '{4'b0101, 3'd4}, '{4'b0001, 3'd3},
      '{4'b0000, 3'd1}, '{4'b0100, 3'd4}, '{4'b0011, 3'd3}, '{4'b0000, 3'd4},
      '{4'b0000, 3'd2}, '{4'b1110, 3'd4}, '{4'b0101, 3'd3}, '{4'b0010, 3'd4},
      '{4'b0011, 3'd2}, '{4'b0001, 3'd2}, '{4'b0111, 3'd3}, '{4'b0110, 3'd4},
      '{4'b1011, 3'd4}, '{4'b0010, 3'd3}, '{4'b0000, 3'd3}, '{4'b0001, 3'd1},
      '{4'b0100, 3'd3}, '{4'b1000, 3'd4}, '{4'b0110, 3'd3}, '{4'b1001, 3'd4},
      '{4'b1101, 3'd4}, '{4'b0011, 3'd4}
   };

   function automatic shape_type shape_of(input logic [4:0] code);
      shape_type s;
      s = '0;
      if (code < SPACE_CODE) begin
         s = SHAPES[code];
      end
      return s;
   endfunction

   typedef struct packed {
      logic [7:0] lamp_level;
      logic       playing;
      logic [5:0] stored_count;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/morse_message_beacon.sv @@
// morse message beacon
// holds a short message of letter codes and flashes it back as morse pulses
// req channel (req_valid / req_stall): one command per transfer on req_func:
//   tick (one millisecond), append letter (req_press_count 1-26 or 30 for a
//   space), delete last, clear, start playback (latches req_brightness)
// rsp channel (rsp_valid / rsp_stall): exactly one result per command, the lamp
//   level, playing flag and stored letter count after that command
// csr port: csr_wr_en / csr_wr_data write the unit length in milliseconds
// the result is registered in the output register behind the request transfer
// throughput: one command per cycle while req_stall is low, set by the single state update and the
//   letter store read, which prefetches the entry after the current one
// when rsp_stall holds the output, the next result lands in a skid stage and
//   req_stall rises only once both are full; nothing is dropped
// reset clears count, playback state and the unit length (back to 100 ms);
//   store contents are kept as they are and only read below the letter count
`default_nettype none

module morse_message_beacon #(
   parameter int MSG_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [2:0] req_func,
   input  wire logic [7:0] req_press_count,
   input  wire logic [7:0] req_brightness,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_lamp_level,
   output      logic       rsp_playing,
   output      logic [5:0] rsp_stored_count,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   // store address width and letter count width
   localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
   localparam int CW = $clog2(MSG_DEPTH + 1);

   // letter store, one write and one registered read per cycle
   logic [4:0]    store_mem [MSG_DEPTH];
   logic [4:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [4:0]    wr_code;

   // playback and message state
   logic [7:0]          unit_ms_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [2:0]          elem_ff, elem_in;
   mmb_pkg::phase_type  phase_ff, phase_in;
   logic [10:0]         cd_ff, cd_in;
   logic [7:0]          bright_ff, bright_in;
   logic [4:0]          cur_ff, cur_in;     // code of the letter being played
   logic [4:0]          head_ff, head_in;   // copy of store entry zero

   // output register and skid stage
   logic              out_valid_ff;
   mmb_pkg::rsp_type  out_ff;
   logic              skid_valid_ff;
   mmb_pkg::rsp_type  skid_ff;
   mmb_pkg::rsp_type  result;

   logic              req_xfer;
   logic              rsp_xfer;

   // decode and next-state helpers
   logic              code_ok;
   logic [4:0]        press_code;
   logic              load_en;
   logic [2:0]        load_units;
   logic [2:0]        elem_nx;
   logic [CW-1:0]     pos_nx;
   logic [CW:0]       rd_nx;
   mmb_pkg::shape_type cur_shape;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;

   // press count to letter code, space is code 26
   always_comb begin
      code_ok    = 1'b0;
      press_code = '0;
      if (req_press_count >= 8'd1 && req_press_count <= mmb_pkg::PRESS_LAST_LETTER) begin
         code_ok    = 1'b1;
         press_code = 5'(req_press_count - 8'd1);
      end else if (req_press_count == mmb_pkg::PRESS_SPACE) begin
         code_ok    = 1'b1;
         press_code = mmb_pkg::SPACE_CODE;
      end
   end

   assign cur_shape = mmb_pkg::shape_of(cur_ff);
   assign elem_nx   = elem_ff + 3'd1;
   assign pos_nx    = pos_ff + CW'(1);

   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      elem_in    = elem_ff;
      phase_in   = phase_ff;
      cd_in      = cd_ff;
      bright_in  = bright_ff;
      cur_in     = cur_ff;
      head_in    = head_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_code    = press_code;
      load_en    = 1'b0;
      load_units = '0;

      if (req_xfer) begin
         if (phase_ff != mmb_pkg::PH_IDLE) begin
            // only ticks count during playback
            if (req_func == mmb_pkg::FUNC_TICK) begin
               if (cd_ff > 11'd1) begin
                  cd_in = cd_ff - 11'd1;
               end else begin
                  unique case (phase_ff)
                     mmb_pkg::PH_LIT: begin
                        phase_in   = mmb_pkg::PH_EGAP;
                        load_en    = 1'b1;
                        load_units = mmb_pkg::UNITS_EGAP;
                     end
                     mmb_pkg::PH_EGAP: begin
                        elem_in = elem_nx;
                        load_en = 1'b1;
                        if (cur_ff < mmb_pkg::SPACE_CODE && elem_nx < mmb_pkg::MAX_ELEMENTS &&
                            elem_nx < cur_shape.len) begin
                           phase_in   = mmb_pkg::PH_LIT;
                           load_units = cur_shape.dash[elem_nx[1:0]] ?
                                        mmb_pkg::UNITS_DASH : mmb_pkg::UNITS_DOT;
                        end else begin
                           phase_in   = mmb_pkg::PH_LGAP;
                           load_units = mmb_pkg::UNITS_LGAP;
                        end
                     end
                     mmb_pkg::PH_LGAP, mmb_pkg::PH_SPACE: begin
                        // next letter comes from the prefetched store read
                        pos_in = pos_nx;
                        if (pos_nx < count_ff) begin
                           elem_in = '0;
                           cur_in  = rd_data_ff;
                           load_en = 1'b1;
                           if (rd_data_ff >= mmb_pkg::SPACE_CODE) begin
                              phase_in   = mmb_pkg::PH_SPACE;
                              load_units = mmb_pkg::UNITS_SPACE;
                           end else begin
                              phase_in   = mmb_pkg::PH_LIT;
                              load_units = mmb_pkg::shape_of(rd_data_ff).dash[0] ?
                                           mmb_pkg::UNITS_DASH : mmb_pkg::UNITS_DOT;
                           end
                        end else begin
                           phase_in = mmb_pkg::PH_IDLE;
                           cd_in    = '0;
                        end
                     end
                     default: begin
                        phase_in = mmb_pkg::PH_IDLE;
                        cd_in    = '0;
                     end
                  endcase
               end
            end
         end else begin
            unique case (req_func)
               mmb_pkg::FUNC_APPEND: begin
                  if (count_ff < CW'(MSG_DEPTH) && code_ok) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                     if (count_ff == '0) begin
                        head_in = press_code;
                     end
                  end
               end
               mmb_pkg::FUNC_DELETE: begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               mmb_pkg::FUNC_CLEAR: begin
                  count_in = '0;
               end
               mmb_pkg::FUNC_START: begin
                  bright_in = req_brightness;
                  pos_in    = '0;
                  if (count_ff != '0) begin
                     elem_in = '0;
                     cur_in  = head_ff;
                     load_en = 1'b1;
                     if (head_ff >= mmb_pkg::SPACE_CODE) begin
                        phase_in   = mmb_pkg::PH_SPACE;
                        load_units = mmb_pkg::UNITS_SPACE;
                     end else begin
                        phase_in   = mmb_pkg::PH_LIT;
                        load_units = mmb_pkg::shape_of(head_ff).dash[0] ?
                                     mmb_pkg::UNITS_DASH : mmb_pkg::UNITS_DOT;
                     end
                  end else begin
                     phase_in = mmb_pkg::PH_IDLE;
                     cd_in    = '0;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // phase length in ticks, at most 7 * 255 so it fits 11 bits
      if (load_en) begin
         cd_in = 11'(load_units) * 11'(unit_ms_ff);
      end
   end

   // read the entry after the next play position
   always_comb begin
      rd_nx = (CW + 1)'(pos_in) + (CW + 1)'(1);
      if (rd_nx < (CW + 1)'(MSG_DEPTH)) begin
         rd_addr = rd_nx[AW-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_code;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ms_ff <= mmb_pkg::UNIT_MS_RESET;
         count_ff   <= '0;
         pos_ff     <= '0;
         elem_ff    <= '0;
         phase_ff   <= mmb_pkg::PH_IDLE;
         cd_ff      <= '0;
         bright_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            unit_ms_ff <= csr_wr_data;
         end
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         elem_ff   <= elem_in;
         phase_ff  <= phase_in;
         cd_ff     <= cd_in;
         bright_ff <= bright_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      head_ff <= head_in;
   end

   // result of this transfer, state after the command
   always_comb begin
      result.lamp_level   = (phase_in == mmb_pkg::PH_LIT) ? bright_in : 8'd0;
      result.playing      = (phase_in != mmb_pkg::PH_IDLE);
      result.stored_count = 6'(count_in);
   end

   // output register with skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_xfer || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_xfer;
            end
         end else if (req_xfer) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_xfer) begin
            out_ff <= result;
         end
      end else if (req_xfer) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_lamp_level   = out_ff.lamp_level;
   assign rsp_playing      = out_ff.playing;
   assign rsp_stored_count = out_ff.stored_count;

   // playback only runs over a non-empty message
   a_play_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != mmb_pkg::PH_IDLE) |-> (count_ff != '0))
      else $error("playback running with an empty store");

   // play position stays inside the stored letters while playing
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != mmb_pkg::PH_IDLE) |-> (pos_ff < count_ff))
      else $error("play position past the stored letters");

   // the store cannot change under playback
   a_count_frozen: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != mmb_pkg::PH_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("letter count changed during playback");

   // skid only fills behind a held output
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full with empty output register");

   // a lit lamp is only reported while playing
   a_lamp_playing: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.lamp_level != 8'd0) |-> out_ff.playing)
      else $error("lamp lit outside playback");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// self-checking bench for the morse message beacon
module tb;

   localparam int STORE_DEPTH  = 32;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // unused func codes, the block must ignore them
   localparam logic [2:0] FUNC_RESERVED_LO  = 3'd5;
   localparam logic [2:0] FUNC_RESERVED_MID = 3'd6;
   localparam logic [2:0] FUNC_RESERVED_HI  = 3'd7;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_HOLD
   } stall_mode_type;

   // predicts every result from the accepted commands and checks them in order
   class beacon_scoreboard;
      string               glyph [mmb_pkg::LETTER_COUNT];
      logic [7:0]          unit_len;
      logic [4:0]          letters [STORE_DEPTH];
      int                  held;
      int                  cursor;
      int                  element;
      mmb_pkg::phase_type  phase;
      int                  countdown;
      logic [7:0]          level;
      mmb_pkg::rsp_type    expected_q [$];
      int                  mismatches;
      int                  checked;
      int                  commands;
      int                  plays;
      int                  lit_results;
      int                  peak_held;

      function new();
         glyph = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                   ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                   "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
         unit_len    = mmb_pkg::UNIT_MS_RESET;
         held        = 0;
         cursor      = 0;
         element     = 0;
         phase       = mmb_pkg::PH_IDLE;
         countdown   = 0;
         level       = '0;
         mismatches  = 0;
         checked     = 0;
         commands    = 0;
         plays       = 0;
         lit_results = 0;
         peak_held   = 0;
      endfunction

      function void set_unit(logic [7:0] value);
         unit_len = value;
      endfunction

      function bit busy();
         return phase != mmb_pkg::PH_IDLE;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int stored();
         return held;
      endfunction

      function void load(mmb_pkg::phase_type next, int units);
         phase     = next;
         countdown = (units * int'(unit_len)) & 'h7FF;
      endfunction

      function int units_of(logic [4:0] code, int idx);
         string g;
         g = glyph[code];
         return (g[idx] == "-") ? 3 : 1;
      endfunction

      function void open_letter();
         if (cursor >= held) begin
            phase     = mmb_pkg::PH_IDLE;
            countdown = 0;
         end else begin
            element = 0;
            if (letters[cursor] >= mmb_pkg::SPACE_CODE) begin
               load(mmb_pkg::PH_SPACE, int'(mmb_pkg::UNITS_SPACE));
            end else begin
               load(mmb_pkg::PH_LIT, units_of(letters[cursor], 0));
            end
         end
      endfunction

      function void advance();
         logic [4:0] code;
         code = letters[cursor];
         case (phase)
            mmb_pkg::PH_LIT: begin
               load(mmb_pkg::PH_EGAP, int'(mmb_pkg::UNITS_EGAP));
            end
            mmb_pkg::PH_EGAP: begin
               element++;
               if (code < mmb_pkg::SPACE_CODE && element < glyph[code].len()) begin
                  load(mmb_pkg::PH_LIT, units_of(code, element));
               end else begin
                  load(mmb_pkg::PH_LGAP, int'(mmb_pkg::UNITS_LGAP));
               end
            end
            mmb_pkg::PH_LGAP, mmb_pkg::PH_SPACE: begin
               cursor++;
               open_letter();
            end
            default: begin
               phase     = mmb_pkg::PH_IDLE;
               countdown = 0;
            end
         endcase
      endfunction

      function void note_command(logic [2:0] func, logic [7:0] press, logic [7:0] bright);
         mmb_pkg::rsp_type want;
         commands++;
         if (phase != mmb_pkg::PH_IDLE) begin
            if (func == mmb_pkg::FUNC_TICK) begin
               if (countdown > 1) begin
                  countdown--;
               end else begin
                  advance();
               end
            end
         end else begin
            case (func)
               mmb_pkg::FUNC_APPEND: begin
                  if (held < STORE_DEPTH) begin
                     if (press >= 1 && press <= mmb_pkg::PRESS_LAST_LETTER) begin
                        letters[held] = 5'(press - 1);
                        held++;
                     end else if (press == mmb_pkg::PRESS_SPACE) begin
                        letters[held] = mmb_pkg::SPACE_CODE;
                        held++;
                     end
                  end
               end
               mmb_pkg::FUNC_DELETE: begin
                  if (held > 0) held--;
               end
               mmb_pkg::FUNC_CLEAR: begin
                  held = 0;
               end
               mmb_pkg::FUNC_START: begin
                  level  = bright;
                  cursor = 0;
                  open_letter();
                  if (phase != mmb_pkg::PH_IDLE) plays++;
               end
               default: begin
               end
            endcase
         end
         want.lamp_level   = (phase == mmb_pkg::PH_LIT) ? level : 8'd0;
         want.playing      = (phase != mmb_pkg::PH_IDLE);
         want.stored_count = 6'(held);
         if (phase == mmb_pkg::PH_LIT) lit_results++;
         if (held > peak_held) peak_held = held;
         expected_q.push_back(want);
      endfunction

      function void check_result(mmb_pkg::rsp_type got);
         mmb_pkg::rsp_type want;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: lamp %0d playing %0d count %0d",
                        got.lamp_level, got.playing, got.stored_count);
            end
            return;
         end
         want = expected_q.pop_front();
         if (got.lamp_level !== want.lamp_level || got.playing !== want.playing ||
             got.stored_count !== want.stored_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("result %0d: expected lamp %0d playing %0d count %0d, ",
                      checked, want.lamp_level, want.playing, want.stored_count);
               $display("got lamp %0d playing %0d count %0d",
                        got.lamp_level, got.playing, got.stored_count);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_func;
   logic [7:0] req_press_count;
   logic [7:0] req_brightness;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_lamp_level;
   logic       rsp_playing;
   logic [5:0] rsp_stored_count;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   beacon_scoreboard sb;
   int             burst_left;
   int             cycle_count = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic [7:0]     cur_unit;

   morse_message_beacon #(
      .MSG_DEPTH(STORE_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_press_count (req_press_count),
      .req_brightness  (req_brightness),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lamp_level  (rsp_lamp_level),
      .rsp_playing     (rsp_playing),
      .rsp_stored_count(rsp_stored_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("morse_message_beacon regression: fail");
         $finish;
      end
   end

   // receiver back-pressure: switch between randomly chosen stall styles,
   // including stretches with no stall at all and long holds
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_HOLD));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= (stall_left % 8 != 0);
      endcase
   end

   // result transfer happens when valid is high and we are not stalling
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(mmb_pkg::rsp_type'({rsp_lamp_level, rsp_playing, rsp_stored_count}));
      end
   end

   // one command transfer; entered and left just after a falling edge.
   // the sender runs in bursts with idle gaps in between
   task automatic send_cmd(input logic [2:0] func, input logic [7:0] press,
                           input logic [7:0] bright);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_valid       = 1'b1;
      req_func        = func;
      req_press_count = press;
      req_brightness  = bright;
      // hold the payload until the transfer goes through
      do @(posedge clock); while (req_stall);
      sb.note_command(func, press, bright);
      burst_left--;
      @(negedge clock);
   endtask

   // keep ticking until playback ends, with ignored commands mixed in
   task automatic tick_out();
      while (sb.busy()) begin
         if ($urandom_range(0, 9) == 0) begin
            send_cmd(3'($urandom_range(mmb_pkg::FUNC_APPEND, FUNC_RESERVED_HI)),
                     8'($urandom), 8'($urandom));
         end else begin
            send_cmd(mmb_pkg::FUNC_TICK, 8'($urandom), 8'($urandom));
         end
      end
   endtask

   // letters A-Z and space typed as press counts
   task automatic append_text(input string text);
      byte c;
      foreach (text[i]) begin
         c = text[i];
         send_cmd(mmb_pkg::FUNC_APPEND,
                  (c == " ") ? mmb_pkg::PRESS_SPACE : 8'(c - "A" + 1), 8'($urandom));
      end
   endtask

   // unit length change, only once the block has drained
   task automatic write_unit(input logic [7:0] value);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_unit(value);
      cur_unit = value;
   endtask

   // mostly valid letters, some spaces, a few arbitrary counts
   function automatic logic [7:0] pick_press();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return 8'($urandom_range(1, mmb_pkg::PRESS_LAST_LETTER));
      if (roll < 95) return mmb_pkg::PRESS_SPACE;
      return 8'($urandom);
   endfunction

   // one random scenario: usually build a message, start it and play it out,
   // sometimes plain noise or a start on an empty store
   task automatic random_episode();
      int n;
      if ($urandom_range(0, 99) < 12) begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            send_cmd(3'($urandom_range(mmb_pkg::FUNC_TICK, FUNC_RESERVED_HI)),
                     8'($urandom), 8'($urandom));
         end
         tick_out();
         return;
      end
      if (sb.stored() > 6 || $urandom_range(0, 2) == 0) begin
         send_cmd(mmb_pkg::FUNC_CLEAR, 8'($urandom), 8'($urandom));
      end
      // an occasional overfill, only while units are short
      if (cur_unit <= 1 && $urandom_range(0, 19) == 0) n = STORE_DEPTH + 4;
      else n = $urandom_range(0, 5);
      repeat (n) begin
         send_cmd(mmb_pkg::FUNC_APPEND, pick_press(), 8'($urandom));
         if ($urandom_range(0, 9) == 0) begin
            send_cmd(mmb_pkg::FUNC_DELETE, 8'($urandom), 8'($urandom));
         end
         if ($urandom_range(0, 14) == 0) begin
            send_cmd(mmb_pkg::FUNC_TICK, 8'($urandom), 8'($urandom));
         end
      end
      send_cmd(mmb_pkg::FUNC_START, 8'($urandom), 8'($urandom));
      tick_out();
   endtask

   initial begin
      int base;
      req_valid       = 1'b0;
      req_func        = mmb_pkg::FUNC_TICK;
      req_press_count = '0;
      req_brightness  = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      burst_left      = 0;
      cur_unit        = mmb_pkg::UNIT_MS_RESET;
      sb              = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle corner cases at the reset unit length
      send_cmd(mmb_pkg::FUNC_TICK, 8'h00, 8'h00);
      send_cmd(FUNC_RESERVED_LO, 8'd1, 8'h11);
      send_cmd(FUNC_RESERVED_MID, 8'd1, 8'h22);
      send_cmd(FUNC_RESERVED_HI, 8'hFF, 8'hFF);
      send_cmd(mmb_pkg::FUNC_DELETE, 8'h00, 8'h00);        // delete on empty store
      send_cmd(mmb_pkg::FUNC_START, 8'h00, 8'hFF);         // empty message, latch only
      send_cmd(mmb_pkg::FUNC_APPEND, 8'd0, 8'h00);         // invalid counts
      send_cmd(mmb_pkg::FUNC_APPEND, 8'd27, 8'h00);
      send_cmd(mmb_pkg::FUNC_APPEND, 8'd29, 8'h00);
      send_cmd(mmb_pkg::FUNC_APPEND, 8'd31, 8'h00);
      send_cmd(mmb_pkg::FUNC_APPEND, 8'hFF, 8'h00);
      send_cmd(mmb_pkg::FUNC_APPEND, 8'd1, 8'h00);         // first and last letter, space
      send_cmd(mmb_pkg::FUNC_APPEND, mmb_pkg::PRESS_LAST_LETTER, 8'h00);
      send_cmd(mmb_pkg::FUNC_APPEND, mmb_pkg::PRESS_SPACE, 8'h00);
      send_cmd(mmb_pkg::FUNC_DELETE, 8'h00, 8'h00);
      send_cmd(mmb_pkg::FUNC_CLEAR, 8'h00, 8'h00);

      // one dot at the reset unit length, with commands that must be ignored mid-play
      append_text("E");
      send_cmd(mmb_pkg::FUNC_START, 8'h00, 8'hA5);
      send_cmd(mmb_pkg::FUNC_APPEND, 8'd5, 8'h00);
      send_cmd(mmb_pkg::FUNC_DELETE, 8'h00, 8'h00);
      send_cmd(mmb_pkg::FUNC_CLEAR, 8'h00, 8'h00);
      send_cmd(mmb_pkg::FUNC_START, 8'h00, 8'h3C);
      send_cmd(FUNC_RESERVED_HI, 8'hFF, 8'hFF);
      tick_out();

      // zero unit length: every phase one tick; fill past the store depth
      write_unit(8'd0);
      send_cmd(mmb_pkg::FUNC_CLEAR, 8'h00, 8'h00);
      repeat (STORE_DEPTH + 2) send_cmd(mmb_pkg::FUNC_APPEND, pick_press(), 8'($urandom));
      send_cmd(mmb_pkg::FUNC_START, 8'h00, 8'h00);
      tick_out();

      // random scenarios, mostly short units so playback stays quick
      base = sb.commands;
      while (sb.commands - base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2:    write_unit(8'd0);
               3, 4, 5, 6: write_unit(8'd1);
               7, 8:       write_unit(8'd2);
               default:    write_unit(8'($urandom_range(3, 5)));
            endcase
         end
         random_episode();
      end

      // drain, then wait on a little longer for stray results
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("%0d commands, %0d results checked, %0d mismatched",
               sb.commands, sb.checked, sb.mismatches);
      $display("%0d playbacks, %0d lit results, up to %0d letters held, units 0 to 5 and 100",
               sb.plays, sb.lit_results, sb.peak_held);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("morse_message_beacon regression: pass");
      end else begin
         $display("morse_message_beacon regression: fail");
      end
      $finish;
   end

endmodule
